// ----- hdl/lphc_pkg.sv -----
`default_nettype none

package lphc_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int SLOT_W      = $clog2(TABLE_DEPTH);
   localparam int CAP_W       = 11;
   localparam int KEY_W       = 64;
   localparam int COUNT_W     = 32;
   localparam int FUNC_W      = 2;
   localparam int STATUS_W    = 2;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(TABLE_DEPTH);
   localparam logic [KEY_W-1:0] EMPTY_KEY = '1;

   // remainder unit: key bits consumed per cycle
   localparam int DIV_BITS   = 4;
   localparam int DIV_STEPS  = KEY_W / DIV_BITS;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

   localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_COUNT  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_GET    = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_NOP    = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_DONE   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_ABSENT = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd2;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [KEY_W-1:0]  key;
      logic              batch_last;
   } req_type;

   typedef struct packed {
      logic [COUNT_W-1:0]  count_value;
      logic [STATUS_W-1:0] status;
      logic                last_of_batch;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIVIDE,
      ST_READ,
      ST_CHECK,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic clear_en;
      logic accept;
      logic mod_start;
      logic probe_start;
      logic rd_en;
      logic step;
      logic commit;
      logic miss;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic req_skip;
      logic mod_done;
      logic key_hit;
      logic key_empty;
      logic is_insert;
      logic last_probe;
      logic rsp_free;
   } stat_type;

endpackage

`default_nettype wire

// ----- hdl/linear_probe_hash_counter.sv -----
// Channel  Ports                                 Direction  Beat
// req      req_valid, req_ready, req_data        in         func, key, batch_last
// rsp      rsp_valid, rsp_ready, rsp_data        out        count_value, status, last_of_batch
// csr      csr_wr_en, csr_wr_data                in         capacity_in_use
//
// One item at a time: a req beat goes through the remainder unit, which
// takes 16 steps of 4 key bits, then its registered done, and then through
// one probe per slot probed; each probe is a registered read of the key and
// count stores followed by a compare.
// Reserved key or unused func: no remainder, no probe.
// After reset the key store is swept to empty, one slot a cycle, over all
// 1024 slots; req_ready stays low meanwhile.
// A finished beat waits in the rsp register; the next req beat is taken
// as soon as the result has been handed to it.
`default_nettype none

module linear_probe_hash_counter (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire lphc_pkg::req_type              req_data,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output lphc_pkg::rsp_type                   rsp_data,
   input  wire logic                           csr_wr_en,
   input  wire logic [lphc_pkg::CAP_W-1:0]     csr_wr_data
);

   lphc_pkg::cmd_type  cmd;
   lphc_pkg::stat_type stat;

   lphc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   lphc_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

   a_zero_on_fail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != lphc_pkg::STATUS_DONE) |->
      rsp_data.count_value == '0)
      else $error("non-zero count with failing status");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second beat accepted while one in flight");

   a_rsp_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.rsp_load))
      else $error("rsp valid raised without a load");

   a_mod_busy: assert property (@(posedge clock) disable iff (reset)
      stat.mod_done |-> !req_ready)
      else $error("remainder finished while accepting");

   a_single_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.commit, cmd.miss, cmd.step, cmd.rd_en, cmd.clear_en}))
      else $error("conflicting probe commands");

endmodule

`default_nettype wire

// ----- hdl/lphc_mod.sv -----
`default_nettype none

module lphc_mod (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [lphc_pkg::KEY_W-1:0]    dividend,
   input  wire logic [lphc_pkg::CAP_W-1:0]    divisor,
   output logic                               done,
   output logic [lphc_pkg::SLOT_W-1:0]        remainder
);

   logic                               busy_ff, busy_in;
   logic                               done_ff, done_in;
   logic [lphc_pkg::DIV_CNT_W-1:0]     cnt_ff, cnt_in;
   logic [lphc_pkg::KEY_W-1:0]         dvd_ff, dvd_in;
   logic [lphc_pkg::CAP_W-1:0]         rem_ff, rem_in;
   logic [lphc_pkg::CAP_W-1:0]         rem_step;

   // restoring remainder, DIV_BITS bits per cycle, msb first
   always_comb begin : rem_calc
      logic [lphc_pkg::CAP_W:0] trial;
      rem_step = rem_ff;
      for (int i = 0; i < lphc_pkg::DIV_BITS; i++) begin
         trial = {rem_step, dvd_ff[lphc_pkg::KEY_W-1-i]};
         if (trial >= {1'b0, divisor}) begin
            trial = trial - {1'b0, divisor};
         end
         rem_step = trial[lphc_pkg::CAP_W-1:0];
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 1'b1;
         dvd_in = dvd_ff << lphc_pkg::DIV_BITS;
         rem_in = rem_step;
         if (cnt_ff == lphc_pkg::DIV_CNT_W'(lphc_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff[lphc_pkg::SLOT_W-1:0];

endmodule

`default_nettype wire

// ----- hdl/lphc_dp.sv -----
`default_nettype none

module lphc_dp (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire lphc_pkg::cmd_type              cmd,
   output lphc_pkg::stat_type                  stat,
   input  wire lphc_pkg::req_type              req_data,
   input  wire logic                           csr_wr_en,
   input  wire logic [lphc_pkg::CAP_W-1:0]     csr_wr_data,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output lphc_pkg::rsp_type                   rsp_data
);

   logic [lphc_pkg::KEY_W-1:0]    key_mem   [lphc_pkg::TABLE_DEPTH];
   logic [lphc_pkg::COUNT_W-1:0]  count_mem [lphc_pkg::TABLE_DEPTH];

   logic [lphc_pkg::CAP_W-1:0]    cap_ff, cap_in;
   logic [lphc_pkg::CAP_W-1:0]    cap_act;
   logic [lphc_pkg::SLOT_W-1:0]   clr_ff, clr_in;
   lphc_pkg::req_type             req_ff;
   logic [lphc_pkg::SLOT_W-1:0]   slot_ff, slot_in;
   logic [lphc_pkg::CAP_W-1:0]    left_ff, left_in;
   logic [lphc_pkg::CAP_W-1:0]    slot_next;
   logic [lphc_pkg::KEY_W-1:0]    key_rd_ff;
   logic [lphc_pkg::COUNT_W-1:0]  count_rd_ff;
   logic [lphc_pkg::STATUS_W-1:0] res_status_ff, res_status_in;
   logic [lphc_pkg::COUNT_W-1:0]  res_count_ff, res_count_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   lphc_pkg::rsp_type             rsp_data_ff;

   logic                          key_we;
   logic [lphc_pkg::SLOT_W-1:0]   key_waddr;
   logic [lphc_pkg::KEY_W-1:0]    key_wdata;
   logic                          count_we;
   logic [lphc_pkg::COUNT_W-1:0]  count_wdata;
   logic [lphc_pkg::COUNT_W-1:0]  count_inc;
   logic                          mod_done;
   logic [lphc_pkg::SLOT_W-1:0]   mod_rem;

   lphc_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.mod_start),
      .dividend  (req_data.key),
      .divisor   (cap_act),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   // zero reads as one, anything past the table saturates
   always_comb begin
      if (cap_ff == '0) begin
         cap_act = lphc_pkg::CAP_W'(1);
      end else if (cap_ff > lphc_pkg::CAP_W'(lphc_pkg::TABLE_DEPTH)) begin
         cap_act = lphc_pkg::CAP_W'(lphc_pkg::TABLE_DEPTH);
      end else begin
         cap_act = cap_ff;
      end
   end

   assign cap_in    = csr_wr_en ? csr_wr_data : cap_ff;
   assign clr_in    = cmd.clear_en ? clr_ff + 1'b1 : clr_ff;
   assign slot_next = lphc_pkg::CAP_W'(slot_ff) + 1'b1;
   assign count_inc = count_rd_ff + 1'b1;

   always_comb begin
      slot_in = slot_ff;
      left_in = left_ff;
      if (cmd.probe_start) begin
         slot_in = mod_rem;
         left_in = cap_act;
      end else if (cmd.step) begin
         slot_in = (slot_next == cap_act) ? '0 : slot_next[lphc_pkg::SLOT_W-1:0];
         left_in = left_ff - 1'b1;
      end
   end

   always_comb begin
      key_we      = 1'b0;
      key_waddr   = slot_ff;
      key_wdata   = req_ff.key;
      count_we    = 1'b0;
      count_wdata = '0;
      if (cmd.clear_en) begin
         key_we    = 1'b1;
         key_waddr = clr_ff;
         key_wdata = lphc_pkg::EMPTY_KEY;
      end else if (cmd.commit) begin
         if (req_ff.func == lphc_pkg::FUNC_INSERT) begin
            key_we   = 1'b1;
            count_we = 1'b1;
         end else if (req_ff.func == lphc_pkg::FUNC_COUNT) begin
            count_we    = 1'b1;
            count_wdata = count_inc;
         end
      end
   end

   always_comb begin
      res_status_in = res_status_ff;
      res_count_in  = res_count_ff;
      if (cmd.accept) begin
         res_status_in = lphc_pkg::STATUS_ABSENT;
         res_count_in  = '0;
      end else if (cmd.commit) begin
         res_status_in = lphc_pkg::STATUS_DONE;
         case (req_ff.func)
            lphc_pkg::FUNC_COUNT: begin
               res_count_in = count_inc;
            end
            lphc_pkg::FUNC_GET: begin
               res_count_in = count_rd_ff;
            end
            default: begin
               res_count_in = '0;
            end
         endcase
      end else if (cmd.miss) begin
         res_status_in = (req_ff.func == lphc_pkg::FUNC_INSERT) ?
                         lphc_pkg::STATUS_FULL : lphc_pkg::STATUS_ABSENT;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= lphc_pkg::CAP_RESET;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cap_ff       <= cap_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         req_ff <= req_data;
      end
      slot_ff       <= slot_in;
      left_ff       <= left_in;
      res_status_ff <= res_status_in;
      res_count_ff  <= res_count_in;
      if (cmd.rsp_load) begin
         rsp_data_ff <= '{count_value:   res_count_ff,
                          status:        res_status_ff,
                          last_of_batch: req_ff.batch_last};
      end
   end

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[key_waddr] <= key_wdata;
      end
      if (cmd.rd_en) begin
         key_rd_ff <= key_mem[slot_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (count_we) begin
         count_mem[slot_ff] <= count_wdata;
      end
      if (cmd.rd_en) begin
         count_rd_ff <= count_mem[slot_ff];
      end
   end

   assign stat.clear_last = (clr_ff == lphc_pkg::SLOT_W'(lphc_pkg::TABLE_DEPTH - 1));
   assign stat.req_skip   = (req_data.key == lphc_pkg::EMPTY_KEY) ||
                            (req_data.func == lphc_pkg::FUNC_NOP);
   assign stat.mod_done   = mod_done;
   assign stat.key_hit    = (key_rd_ff == req_ff.key);
   assign stat.key_empty  = (key_rd_ff == lphc_pkg::EMPTY_KEY);
   assign stat.is_insert  = (req_ff.func == lphc_pkg::FUNC_INSERT);
   assign stat.last_probe = (left_ff == lphc_pkg::CAP_W'(1));
   assign stat.rsp_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ----- hdl/lphc_ctrl.sv -----
`default_nettype none

module lphc_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire lphc_pkg::stat_type   stat,
   output lphc_pkg::cmd_type         cmd
);

   lphc_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lphc_pkg::ST_CLEAR: begin
            if (stat.clear_last) begin
               state_in = lphc_pkg::ST_IDLE;
            end
         end
         lphc_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = stat.req_skip ? lphc_pkg::ST_FINISH : lphc_pkg::ST_DIVIDE;
            end
         end
         lphc_pkg::ST_DIVIDE: begin
            if (stat.mod_done) begin
               state_in = lphc_pkg::ST_READ;
            end
         end
         lphc_pkg::ST_READ: begin
            state_in = lphc_pkg::ST_CHECK;
         end
         lphc_pkg::ST_CHECK: begin
            if (stat.key_hit || stat.key_empty || stat.last_probe) begin
               state_in = lphc_pkg::ST_FINISH;
            end else begin
               state_in = lphc_pkg::ST_READ;
            end
         end
         lphc_pkg::ST_FINISH: begin
            if (stat.rsp_free) begin
               state_in = lphc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lphc_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         lphc_pkg::ST_CLEAR: begin
            cmd.clear_en = 1'b1;
         end
         lphc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept    = 1'b1;
               cmd.mod_start = !stat.req_skip;
            end
         end
         lphc_pkg::ST_DIVIDE: begin
            cmd.probe_start = stat.mod_done;
         end
         lphc_pkg::ST_READ: begin
            cmd.rd_en = 1'b1;
         end
         lphc_pkg::ST_CHECK: begin
            if (stat.key_hit || (stat.key_empty && stat.is_insert)) begin
               cmd.commit = 1'b1;
            end else if (stat.key_empty || stat.last_probe) begin
               cmd.miss = 1'b1;
            end else begin
               cmd.step = 1'b1;
            end
         end
         lphc_pkg::ST_FINISH: begin
            cmd.rsp_load = stat.rsp_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lphc_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ----- dv/lphc_checker.sv -----
module lphc_checker
   import lphc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  req_type          req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  rsp_type          rsp_data,
   input  logic             csr_wr_en,
   input  logic [CAP_W-1:0] csr_wr_data,
   input  logic             run_over,
   output int               errors
);

   logic [KEY_W-1:0]   slot_key   [TABLE_DEPTH];
   logic [COUNT_W-1:0] slot_count [TABLE_DEPTH];
   logic [CAP_W-1:0]   capacity = CAP_RESET;
   rsp_type            due_q [$];
   int                 fail_count = 0;
   int                 n_done = 0;
   int                 n_absent = 0;
   int                 n_full = 0;
   bit                 closed = 1'b0;

   assign errors = fail_count;

   task automatic report_mismatch(input string what);
      fail_count++;
      $display("lphc_checker: %0t: %s", $time, what);
   endtask

   // walks the table the way the block does; updates the shadow stores
   function automatic rsp_type predict_outcome(input req_type beat);
      rsp_type     outcome;
      int unsigned span;
      int unsigned slot;
      bit          hit;
      bit          vacant;
      outcome.count_value   = '0;
      outcome.status        = STATUS_ABSENT;
      outcome.last_of_batch = beat.batch_last;
      if (beat.key == EMPTY_KEY || beat.func == FUNC_NOP) return outcome;
      span = capacity;
      if (span == 0) span = 1;
      if (span > TABLE_DEPTH) span = TABLE_DEPTH;
      slot   = 32'(beat.key % 64'(span));
      hit    = 1'b0;
      vacant = 1'b0;
      for (int n = 0; n < span && !hit && !vacant; n++) begin
         if (slot_key[slot] == beat.key) begin
            hit = 1'b1;
         end else if (slot_key[slot] == EMPTY_KEY) begin
            vacant = 1'b1;
         end else begin
            slot = (slot + 1 == span) ? 0 : slot + 1;
         end
      end
      if (beat.func == FUNC_INSERT) begin
         if (hit || vacant) begin
            slot_key[slot]   = beat.key;
            slot_count[slot] = '0;
            outcome.status   = STATUS_DONE;
         end else begin
            outcome.status = STATUS_FULL;
         end
      end else if (hit) begin
         if (beat.func == FUNC_COUNT) slot_count[slot] = slot_count[slot] + 1'b1;
         outcome.count_value = slot_count[slot];
         outcome.status      = STATUS_DONE;
      end
      return outcome;
   endfunction

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < TABLE_DEPTH; i++) slot_key[i] = EMPTY_KEY;
         capacity = CAP_RESET;
         due_q.delete();
      end else begin
         // response first: a request taken on this edge cannot answer on it
         if (rsp_valid && rsp_ready) begin
            if (due_q.size() == 0) begin
               report_mismatch("response beat with no request outstanding");
            end else begin
               want = due_q.pop_front();
               if (rsp_data.count_value !== want.count_value)
                  report_mismatch($sformatf("count_value %0d, predicted %0d",
                                            rsp_data.count_value, want.count_value));
               if (rsp_data.status !== want.status)
                  report_mismatch($sformatf("status %0d, predicted %0d",
                                            rsp_data.status, want.status));
               if (rsp_data.last_of_batch !== want.last_of_batch)
                  report_mismatch($sformatf("last_of_batch %b, predicted %b",
                                            rsp_data.last_of_batch, want.last_of_batch));
            end
         end
         if (req_valid && req_ready) begin
            want = predict_outcome(req_data);
            due_q.push_back(want);
            if (want.status == STATUS_DONE) n_done++;
            else if (want.status == STATUS_FULL) n_full++;
            else n_absent++;
         end
         if (csr_wr_en) capacity = csr_wr_data;
         if (run_over && !closed) begin
            closed = 1'b1;
            if (due_q.size() != 0)
               report_mismatch($sformatf("%0d predicted responses never arrived",
                                         due_q.size()));
            $display("lphc_checker: outcomes seen: %0d done, %0d absent, %0d table full",
                     n_done, n_absent, n_full);
         end
      end
   end

endmodule

// ----- dv/tb_top.sv -----
module tb_top;
   import lphc_pkg::*;

   localparam int ITEM_TARGET = 1950;
   localparam int POOL_SIZE   = 40;
   localparam int CYCLE_LIMIT = 40_000_000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   req_type          req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   rsp_type          rsp_data;
   logic             csr_wr_en = 1'b0;
   logic [CAP_W-1:0] csr_wr_data = '0;
   logic             run_over = 1'b0;
   int               errors;

   int               sent = 0;
   int               received = 0;
   int               phases = 0;
   int               cycle_count = 0;
   int               rsp_hold = 0;
   bit               calm = 1'b0;
   int unsigned      span = TABLE_DEPTH;
   int unsigned      pool_base = 0;
   int unsigned      pool_len = 1;
   logic [KEY_W-1:0] key_pool [POOL_SIZE];

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   linear_probe_hash_counter dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   lphc_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .run_over    (run_over),
      .errors      (errors)
   );

   // mostly short gaps, a few long ones; none in a calm phase
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic req_type make_beat(input logic [FUNC_W-1:0] func,
                                         input logic [KEY_W-1:0] key,
                                         input logic last);
      req_type beat;
      beat.func       = func;
      beat.key        = key;
      beat.batch_last = last;
      return beat;
   endfunction

   function automatic req_type random_beat();
      req_type beat;
      int      pick;
      pick = $urandom_range(0, 99);
      beat.batch_last = 1'($urandom_range(0, 1));
      if (pick < 5) beat.func = FUNC_NOP;
      else if (pick < 32) beat.func = FUNC_INSERT;
      else if (pick < 70) beat.func = FUNC_COUNT;
      else beat.func = FUNC_GET;
      pick = $urandom_range(0, 99);
      if (pick < 82) begin
         beat.key = key_pool[(pool_base + $urandom_range(0, pool_len - 1)) % POOL_SIZE];
      end else begin
         if (pick < 90) beat.key = {$urandom, $urandom};
         else if (pick < 94) beat.key = EMPTY_KEY;
         else if (pick < 97) beat.key = EMPTY_KEY - 1'b1;
         else beat.key = 64'($urandom_range(0, 2 * span));
         // one-off keys are looked up, not stored, so the table keeps room
         if (beat.func == FUNC_INSERT && pick < 90) beat.func = FUNC_GET;
      end
      return beat;
   endfunction

   task automatic send_beat(input req_type beat);
      int gap;
      req_data <= beat;
      if (!req_valid) req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent++;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      if (req_valid) req_valid <= 1'b0;
      while (received != sent) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] value);
      csr_wr_data <= value;
      csr_wr_en   <= 1'b1;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   always @(posedge clock) begin : ready_gen
      int len;
      if (rsp_hold > 0) begin
         rsp_hold <= rsp_hold - 1;
      end else begin
         len = pick_gap();
         if (len == 0) begin
            rsp_ready <= 1'b1;
            rsp_hold  <= $urandom_range(0, 4);
         end else begin
            rsp_ready <= 1'b0;
            rsp_hold  <= len - 1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (rsp_valid && rsp_ready) received <= received + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_top: done, errors");
         $finish;
      end
   end

   initial begin : stimulus
      logic [CAP_W-1:0] cap;
      int               pick;
      int               n_items;
      for (int i = 0; i < POOL_SIZE; i++) begin
         do key_pool[i] = {$urandom, $urandom};
         while (key_pool[i] == EMPTY_KEY);
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // full capacity: collisions, extremes of key, reserved key, no-op
      send_beat(make_beat(FUNC_GET,    64'd0, 1'b0));
      send_beat(make_beat(FUNC_INSERT, 64'd0, 1'b0));
      send_beat(make_beat(FUNC_INSERT, 64'd1024, 1'b0));
      send_beat(make_beat(FUNC_COUNT,  64'd1024, 1'b0));
      send_beat(make_beat(FUNC_COUNT,  64'd1024, 1'b1));
      send_beat(make_beat(FUNC_GET,    64'd1024, 1'b0));
      send_beat(make_beat(FUNC_INSERT, EMPTY_KEY - 1'b1, 1'b0));
      send_beat(make_beat(FUNC_COUNT,  EMPTY_KEY - 1'b1, 1'b1));
      send_beat(make_beat(FUNC_INSERT, EMPTY_KEY, 1'b0));
      send_beat(make_beat(FUNC_COUNT,  EMPTY_KEY, 1'b1));
      send_beat(make_beat(FUNC_GET,    EMPTY_KEY, 1'b0));
      send_beat(make_beat(FUNC_NOP,    64'd0, 1'b1));
      send_beat(make_beat(FUNC_INSERT, 64'd1024, 1'b0));
      send_beat(make_beat(FUNC_GET,    64'd1024, 1'b0));
      send_beat(make_beat(FUNC_COUNT,  64'd2048, 1'b1));

      // one slot: full table, slot 1 hidden
      wait_idle();
      write_capacity(11'd1);
      send_beat(make_beat(FUNC_INSERT, 64'd5, 1'b0));
      send_beat(make_beat(FUNC_COUNT,  64'd5, 1'b1));
      send_beat(make_beat(FUNC_GET,    64'd1024, 1'b0));
      send_beat(make_beat(FUNC_COUNT,  64'd0, 1'b0));
      wait_idle();
      write_capacity(11'd0);
      send_beat(make_beat(FUNC_GET,    64'd0, 1'b1));
      wait_idle();
      write_capacity('1);
      send_beat(make_beat(FUNC_GET,    64'd1024, 1'b0));
      send_beat(make_beat(FUNC_GET,    EMPTY_KEY - 1'b1, 1'b1));
      wait_idle();
      write_capacity(11'd2);
      send_beat(make_beat(FUNC_INSERT, 64'd3, 1'b0));
      send_beat(make_beat(FUNC_GET,    64'd0, 1'b1));

      while (sent < ITEM_TARGET) begin
         wait_idle();
         pick = $urandom_range(0, 19);
         case (pick)
            0:       cap = '0;
            1:       cap = 11'd1;
            2:       cap = CAP_RESET;
            3:       cap = '1;
            4:       cap = CAP_W'($urandom_range(1025, 2047));
            5, 6, 7: cap = CAP_W'($urandom_range(0, 2047));
            default: cap = CAP_W'($urandom_range(2, 48));
         endcase
         write_capacity(cap);
         phases++;
         span      = (cap == 0) ? 1 : ((cap > TABLE_DEPTH) ? TABLE_DEPTH : cap);
         calm      = ($urandom_range(0, 3) == 0);
         pool_base = $urandom_range(0, POOL_SIZE - 1);
         pool_len  = $urandom_range(2, 12);
         n_items   = (span >= 256) ? $urandom_range(5, 20) : $urandom_range(10, 60);
         repeat (n_items) send_beat(random_beat());
      end

      wait_idle();
      calm = 1'b0;
      repeat (64) @(posedge clock);
      run_over <= 1'b1;
      repeat (2) @(posedge clock);
      $display("tb_top: %0d request beats, %0d response beats, %0d random capacity phases",
               sent, received, phases);
      if (errors == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule
